// File: hdl/bitmap_set_clear_bit_search_macros.svh
// Assertion macros for the bitmap bit search block.
`ifndef BITMAP_SET_CLEAR_BIT_SEARCH_MACROS_SVH
`define BITMAP_SET_CLEAR_BIT_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap search check failed");

// Next-cycle implication, checked outside reset.
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap search check failed");

`endif

// File: hdl/bmsrch_pkg.sv
// Shared constants, types and bit-scan functions for the bitmap search block.
package bmsrch_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 12;
  localparam int WIDX_W   = 6;
  localparam int WORD_W   = 64;
  localparam int SIZE_W   = 13;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int MAP_WORDS_DEF = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
  localparam logic [WORD_W-1:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

  localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT_SET   = 3'd1;
  localparam logic [OP_W-1:0] OP_NEXT_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_PREV_SET   = 3'd3;
  localparam logic [OP_W-1:0] OP_PREV_CLEAR = 3'd4;

  // register select bit (paddr[2])
  localparam logic REG_MAP_SIZE = 1'b0;

  typedef struct packed {
    logic accept;     // capture item, start first read
    logic step;       // advance to neighbor word
    logic hold_word;  // latch masked nonzero word
    logic clr_res;    // result: not found
    logic set_res;    // result: from bit scan
    logic load_out;   // move result to output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_search;
    logic start_oob;
    logic word_nz;
    logic at_end;
  } ctrl_sts_t;

  // lowest set bit index, binary narrowing
  function automatic logic [5:0] ctz64(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    logic [5:0]        n;
    v = w;
    n = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((v & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
        n = n + 6'(1 << k);
        v = v >> (1 << k);
      end
    end
    return n;
  endfunction

  // highest set bit index, 0 for a zero word
  function automatic logic [5:0] msb64(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    logic [5:0]        n;
    v = w;
    n = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((v >> (1 << k)) != 64'd0) begin
        n = n + 6'(1 << k);
        v = v >> (1 << k);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/bmsrch_if.sv
// Item channel interfaces: request items in, result items out.
interface bmsrch_cmd_if;
  import bmsrch_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    start_position;
  logic [WIDX_W-1:0]   word_index;
  logic [WORD_W-1:0]   word_value;

  modport source (output valid, operation, start_position, word_index, word_value,
                  input ready);
  modport sink   (input valid, operation, start_position, word_index, word_value,
                  output ready);
endinterface

interface bmsrch_rsp_if;
  import bmsrch_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] bit_position;

  modport source (output valid, found, bit_position, input ready);
  modport sink   (input valid, found, bit_position, output ready);
endinterface

// File: hdl/bmsrch_ctrl.sv
// Sequencer for one item at a time: accept, word scan, bit encode, result hand-off.
module bmsrch_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  output bmsrch_pkg::ctrl_cmd_t ctl,
  input  bmsrch_pkg::ctrl_sts_t sts
);
  import bmsrch_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ENCODE, S_DONE} state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    res_valid_next = res_valid && !res_ready;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.accept = 1'b1;
          if (sts.is_search && !sts.start_oob) begin
            state_next = S_SCAN;
          end else begin
            ctl.clr_res = 1'b1;
            state_next  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (sts.word_nz) begin
          ctl.hold_word = 1'b1;
          state_next    = S_ENCODE;
        end else if (sts.at_end) begin
          ctl.clr_res = 1'b1;
          state_next  = S_DONE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_ENCODE: begin
        ctl.set_res = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          ctl.load_out   = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

// File: hdl/bmsrch_dp.sv
// Datapath: map memory with valid bits, word walker, masking, bit scan, result registers.
module bmsrch_dp #(
  parameter int MAP_WORDS = bmsrch_pkg::MAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmsrch_pkg::ctrl_cmd_t         ctl,
  output bmsrch_pkg::ctrl_sts_t         sts,
  input  logic [bmsrch_pkg::SIZE_W-1:0] map_size_bits,
  input  logic [bmsrch_pkg::OP_W-1:0]   operation,
  input  logic [bmsrch_pkg::POS_W-1:0]  start_position,
  input  logic [bmsrch_pkg::WIDX_W-1:0] word_index,
  input  logic [bmsrch_pkg::WORD_W-1:0] word_value,
  output logic                          found,
  output logic [bmsrch_pkg::POS_W-1:0]  bit_position
);
  import bmsrch_pkg::*;

  localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP    = MAP_WORDS * WORD_W;
  localparam int CAP_W  = $clog2(CAP + 1);
  localparam int EW     = (CAP_W > SIZE_W) ? CAP_W : SIZE_W;
  localparam int CMP_W  = EW + 1;
  localparam int BPOS_W = AW + 6;

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] wvalid;

  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              rd_valid;

  logic [AW-1:0]     ptr;
  logic [AW-1:0]     ptr_next;
  logic [5:0]        from_low;
  logic              fwd;
  logic              inv;
  logic              first;
  logic [WORD_W-1:0] wreg;
  logic              res_found;
  logic [POS_W-1:0]  res_pos;

  logic [EW-1:0]     eff_size;
  logic [CMP_W-1:0]  nwords;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] wcur;
  logic [BPOS_W-1:0] hit_pos;
  logic              hit_ok;
  logic              wr_en;
  logic [AW-1:0]     start_word;

  // effective size saturates at the map capacity
  assign eff_size = (EW'(map_size_bits) > EW'(CAP)) ? EW'(CAP) : EW'(map_size_bits);
  assign nwords   = (CMP_W'(eff_size) + CMP_W'(63)) >> 6;

  assign start_word = AW'(start_position[POS_W-1:6]);
  assign ptr_next   = fwd ? (ptr + AW'(1)) : (ptr - AW'(1));
  assign rd_addr    = ctl.step ? ptr_next : start_word;

  assign wr_en = ctl.accept && (operation == OP_WRITE) && (32'(word_index) < MAP_WORDS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(word_index)] <= word_value;
    end
    rd_data <= mem[rd_addr];
  end

  // unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (wr_en) begin
      wvalid[AW'(word_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= wvalid[rd_addr];
  end

  always_comb begin
    if (!first) begin
      mask = ALL_ONES;
    end else if (fwd) begin
      mask = ALL_ONES << from_low;
    end else begin
      mask = ALL_ONES >> (6'd63 - from_low);
    end
  end

  assign wcur = ((rd_valid ? rd_data : '0) ^ {WORD_W{inv}}) & mask;

  assign sts.is_search = (operation == OP_NEXT_SET) || (operation == OP_NEXT_CLEAR) ||
                         (operation == OP_PREV_SET) || (operation == OP_PREV_CLEAR);
  assign sts.start_oob = EW'(start_position) >= eff_size;
  assign sts.word_nz   = (wcur != '0);
  assign sts.at_end    = fwd ? ((CMP_W'(ptr) + CMP_W'(1)) >= nwords) : (ptr == '0);

  assign hit_pos = fwd ? {ptr, ctz64(wreg)} : {ptr, msb64(wreg)};
  assign hit_ok  = !fwd || (CMP_W'(hit_pos) < CMP_W'(eff_size));

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      fwd      <= (operation == OP_NEXT_SET) || (operation == OP_NEXT_CLEAR);
      inv      <= (operation == OP_NEXT_CLEAR) || (operation == OP_PREV_CLEAR);
      from_low <= start_position[5:0];
      ptr      <= start_word;
      first    <= 1'b1;
    end else if (ctl.step) begin
      ptr   <= ptr_next;
      first <= 1'b0;
    end
    if (ctl.hold_word) begin
      wreg <= wcur;
    end
    if (ctl.clr_res) begin
      res_found <= 1'b0;
      res_pos   <= '0;
    end else if (ctl.set_res) begin
      res_found <= hit_ok;
      res_pos   <= hit_ok ? POS_W'(hit_pos) : '0;
    end
    if (ctl.load_out) begin
      found        <= res_found;
      bit_position <= res_pos;
    end
  end

endmodule

// File: hdl/bitmap_set_clear_bit_search.sv
// Bitmap bit search: writes and misses at start go from accept straight to the done state;
// a search walks the map (one memory read a cycle), then encodes a hit or stops at the edge.
// An item occupies the block from its accept to the next possible accept, which comes once
// its result has moved to the output register.
// A new item is taken while the previous result still waits in the output register.
// Synchronous reset: map words read as zero (per-word valid bits cleared), size 4096.
`include "bitmap_set_clear_bit_search_macros.svh"

module bitmap_set_clear_bit_search #(
  parameter int MAP_WORDS = bmsrch_pkg::MAP_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bmsrch_cmd_if.sink                     cmd,
  bmsrch_rsp_if.source                   rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmsrch_pkg::PADDR_W-1:0] paddr,
  input  logic [bmsrch_pkg::PDATA_W-1:0] pwdata,
  output logic [bmsrch_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import bmsrch_pkg::*;

  // Configuration: one register, map_size_bits, at byte address 0.
  // Written on APB access; the user must change it only while the block is idle (unchecked).
  logic [SIZE_W-1:0] map_size_bits;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAP_SIZE) ? PDATA_W'(map_size_bits) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size_bits <= SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAP_SIZE)) begin
      map_size_bits <= pwdata[SIZE_W-1:0];
    end
  end

  // Controller and datapath. The controller walks:
  //   idle -> (write / bad op / start past size) -> done
  //   idle -> scan (one word per cycle) -> encode -> done
  //   scan -> done when the walk hits the map edge with nothing found
  // done hands the result to the output register once it is free.
  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  bmsrch_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd.valid),
    .item_ready (cmd.ready),
    .res_valid  (rsp.valid),
    .res_ready  (rsp.ready),
    .ctl        (ctl),
    .sts        (sts)
  );

  bmsrch_dp #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .map_size_bits  (map_size_bits),
    .operation      (cmd.operation),
    .start_position (cmd.start_position),
    .word_index     (cmd.word_index),
    .word_value     (cmd.word_value),
    .found          (rsp.found),
    .bit_position   (rsp.bit_position)
  );

  // A reported hit always lies inside the configured size.
  `BMS_ASSERT_NOW(a_hit_in_range, rsp.valid && rsp.found, SIZE_W'(rsp.bit_position) < map_size_bits)
  // A miss reports position zero.
  `BMS_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.found, rsp.bit_position == '0)
  // One item at a time: no accept in the cycle after an accept.
  `BMS_ASSERT_NEXT(a_one_item, cmd.valid && cmd.ready, !cmd.ready)

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the bitmap bit search block: writes, searches, size register.
module testbench;
  import bmsrch_pkg::*;

  // Operation codes the block must ignore (no map change, not-found answer).
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_MAP_SIZE, 2'b00};
  localparam int unsigned MAP_BITS      = MAP_WORDS_DEF * WORD_W;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Longest search: accept, a read of every map word, result register, plus margin.
  localparam int unsigned SETTLE_CYCLES = 90;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  start_position;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
  } map_request_t;

  typedef struct {
    map_request_t req;
    int unsigned  gap;    // idle cycles before this item is offered
    bit           drain;  // hold the item until every answer is back
  } queued_request_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_answer_t;

  logic clk = 1'b0;
  logic rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  bmsrch_cmd_if cmd_ch ();
  bmsrch_rsp_if rsp_ch ();

  bitmap_set_clear_bit_search dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the block: map contents and size register.
  logic [WORD_W-1:0] map_shadow [MAP_WORDS_DEF];
  logic [SIZE_W-1:0] size_setting;

  queued_request_t request_queue [$];
  search_answer_t  answers_due [$];
  int unsigned     requests_left = 0;  // queued but not yet accepted
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     sender_calm = 0;
  int unsigned     receiver_calm = 0;
  map_request_t    on_wire;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Size register saturates at the map capacity.
  function automatic int unsigned live_bits();
    return (size_setting > MAP_BITS) ? MAP_BITS : int'(size_setting);
  endfunction

  function automatic logic [WORD_W-1:0] shadow_word(input int unsigned idx, input bit flip);
    return flip ? ~map_shadow[idx] : map_shadow[idx];
  endfunction

  // Forward walk: lowest hit at or above the start; hits past the size don't count,
  // which also hides the clear bits past the end of the map.
  function automatic search_answer_t scan_up(input int unsigned from, input bit flip);
    search_answer_t ans;
    int unsigned    lim, nwords, idx, low;
    logic [WORD_W-1:0] w;
    ans = '0;
    lim = live_bits();
    nwords = (lim + 63) / 64;
    idx = from / 64;
    if (from >= lim) return ans;
    w = shadow_word(idx, flip) & (ALL_ONES << (from % 64));
    while (1) begin
      if (w != '0) begin
        low = 0;
        for (int b = 63; b >= 0; b--) if (w[b]) low = b;
        if (idx * 64 + low < lim) begin
          ans.found = 1'b1;
          ans.position = POS_W'(idx * 64 + low);
        end
        return ans;
      end
      idx++;
      if (idx >= nwords) return ans;
      w = shadow_word(idx, flip);
    end
  endfunction

  // Backward walk: highest hit at or below the start, down to bit 0.
  function automatic search_answer_t scan_down(input int unsigned from, input bit flip);
    search_answer_t ans;
    int unsigned    idx, high;
    logic [WORD_W-1:0] w;
    ans = '0;
    idx = from / 64;
    if (from >= live_bits()) return ans;
    w = shadow_word(idx, flip) & (ALL_ONES >> (63 - from % 64));
    while (1) begin
      if (w != '0) begin
        high = 0;
        for (int b = 0; b < 64; b++) if (w[b]) high = b;
        ans.found = 1'b1;
        ans.position = POS_W'(idx * 64 + high);
        return ans;
      end
      if (idx == 0) return ans;
      idx--;
      w = shadow_word(idx, flip);
    end
  endfunction

  // Applies one accepted item to the shadow and returns its answer.
  function automatic search_answer_t answer_request(input map_request_t r);
    search_answer_t ans;
    ans = '0;
    case (r.operation)
      OP_WRITE:      map_shadow[r.word_index] = r.word_value;
      OP_NEXT_SET:   ans = scan_up(r.start_position, 1'b0);
      OP_NEXT_CLEAR: ans = scan_up(r.start_position, 1'b1);
      OP_PREV_SET:   ans = scan_down(r.start_position, 1'b0);
      OP_PREV_CLEAR: ans = scan_down(r.start_position, 1'b1);
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random wait, with occasional stretches of back-to-back traffic.
  function automatic int unsigned pick_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void push_request(input logic [OP_W-1:0] op,
                                       input logic [POS_W-1:0] start,
                                       input logic [WIDX_W-1:0] widx,
                                       input logic [WORD_W-1:0] value);
    queued_request_t q;
    q.req.operation      = op;
    q.req.start_position = start;
    q.req.word_index     = widx;
    q.req.word_value     = value;
    q.gap   = pick_wait(sender_calm);
    q.drain = ($urandom_range(0, 149) == 0);
    request_queue.push_back(q);
    requests_left++;
  endfunction

  // Starts lean on the size edge, word edges and out-of-range values.
  function automatic logic [POS_W-1:0] pick_start();
    int unsigned lim;
    lim = live_bits();
    case ($urandom_range(0, 9))
      0: return POS_W'(lim - 1);
      1: return POS_W'(lim);
      2: return POS_W'($urandom_range(0, 63) * 64 + ($urandom_range(0, 1) ? 63 : 0));
      3: return POS_W'($urandom());
      default: return (lim == 0) ? POS_W'($urandom()) : POS_W'($urandom_range(0, lim - 1));
    endcase
  endfunction

  // 0 zero, 1 ones, 2 one bit set, 3 one bit clear, 4 sparse, 5 dense, else random.
  function automatic logic [WORD_W-1:0] pick_word(input int unsigned kind);
    logic [WORD_W-1:0] one_bit;
    one_bit = 64'd1 << $urandom_range(0, 63);
    case (kind)
      0: return '0;
      1: return ALL_ONES;
      2: return one_bit;
      3: return ~one_bit;
      4: return {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
      5: return {$urandom(), $urandom()} | {$urandom(), $urandom()} | {$urandom(), $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_search_op();
    case ($urandom_range(0, 3))
      0: return OP_NEXT_SET;
      1: return OP_NEXT_CLEAR;
      2: return OP_PREV_SET;
      default: return OP_PREV_CLEAR;
    endcase
  endfunction

  // Random traffic. Whole-map sweeps set up empty, full, sparse, dense or random maps so that
  // searches walk many words; single writes, searches and unused codes mix in between.
  task automatic run_random(input int unsigned count);
    int unsigned done, pattern, roll;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 11) == 0) begin
        pattern = $urandom_range(0, 4);
        for (int w = 0; w < MAP_WORDS_DEF; w++) begin
          case (pattern)
            0: push_request(OP_WRITE, pick_start(), WIDX_W'(w), pick_word(0));
            1: push_request(OP_WRITE, pick_start(), WIDX_W'(w), pick_word(1));
            2: push_request(OP_WRITE, pick_start(), WIDX_W'(w),
                            pick_word(($urandom_range(0, 15) == 0) ? 2 : 0));
            3: push_request(OP_WRITE, pick_start(), WIDX_W'(w),
                            pick_word(($urandom_range(0, 15) == 0) ? 3 : 1));
            default: push_request(OP_WRITE, pick_start(), WIDX_W'(w),
                                  pick_word($urandom_range(0, 6)));
          endcase
        end
        done += MAP_WORDS_DEF;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25)
          push_request(OP_WRITE, pick_start(), WIDX_W'($urandom()),
                       pick_word($urandom_range(0, 6)));
        else if (roll < 95)
          push_request(pick_search_op(), pick_start(), WIDX_W'($urandom()),
                       {$urandom(), $urandom()});
        else
          push_request(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                       POS_W'($urandom()), WIDX_W'($urandom()), {$urandom(), $urandom()});
        done++;
      end
    end
  endtask

  // Waits until every queued item is accepted and answered, then lets it settle.
  task automatic wait_idle(input int unsigned settle);
    while (requests_left != 0 || answers_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic void log_mismatch(input string what, input longint unsigned want,
                                       input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // Size register write (setup + access), then a read back of the same register.
  task automatic set_map_size(input int unsigned bits);
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= PDATA_W'(bits);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_setting = SIZE_W'(bits);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[SIZE_W-1:0] !== size_setting)
      log_mismatch("map size read back", size_setting, got[SIZE_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, holds each until accepted
  // ---------------------------------------------------------------------------
  int unsigned gap_count;
  always @(posedge clk) begin : request_drive
    logic            fire, offer;
    queued_request_t head;
    fire  = cmd_ch.valid && cmd_ch.ready;
    offer = cmd_ch.valid && !fire;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_count = 0;
    end else begin
      // Predict at acceptance: the map changes in item order.
      if (fire) begin
        answers_due.push_back(answer_request(on_wire));
        requests_left--;
      end
      if (!offer && request_queue.size() != 0) begin
        if (gap_count < request_queue[0].gap) begin
          gap_count++;
        end else if (!(request_queue[0].drain && answers_due.size() != 0)) begin
          head = request_queue.pop_front();
          on_wire = head.req;
          cmd_ch.operation      <= head.req.operation;
          cmd_ch.start_position <= head.req.start_position;
          cmd_ch.word_index     <= head.req.word_index;
          cmd_ch.word_value     <= head.req.word_value;
          offer = 1'b1;
          gap_count = 0;
        end
      end
      // single assignment: valid stays high across back-to-back items
      cmd_ch.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, compares each result with the oldest answer
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  always @(posedge clk) begin : result_check
    search_answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          log_mismatch("result item with none outstanding (found)", 0, rsp_ch.found);
        end else begin
          want = answers_due.pop_front();
          if (rsp_ch.found !== want.found)
            log_mismatch("found", want.found, rsp_ch.found);
          if (rsp_ch.bit_position !== want.position)
            log_mismatch("bit_position", want.position, rsp_ch.bit_position);
        end
        stall_left = pick_wait(receiver_calm);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned size_plan [11];
    rst = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.operation      = OP_WRITE;
    cmd_ch.start_position = '0;
    cmd_ch.word_index     = '0;
    cmd_ch.word_value     = '0;
    rsp_ch.ready          = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    on_wire = '0;
    for (int w = 0; w < MAP_WORDS_DEF; w++) map_shadow[w] = '0;
    size_setting = SIZE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset size on an empty map.
    push_request(OP_NEXT_SET,   '0,              '0, '0);        // empty map: full walk, miss
    push_request(OP_PREV_SET,   POS_W'(4095),    '0, '0);        // empty map, backward miss
    push_request(OP_NEXT_CLEAR, POS_W'(4095),    '0, '0);        // last bit
    push_request(OP_PREV_CLEAR, '0,              '0, '0);        // first bit
    push_request(OP_WRITE,      '0, WIDX_W'(63), 64'd1 << 63);   // top bit of the map
    push_request(OP_NEXT_SET,   '0,              '0, '0);        // long walk to the top
    push_request(OP_WRITE,      '0,              '0, ALL_ONES);
    push_request(OP_NEXT_CLEAR, '0,              '0, '0);        // first clear in word 1
    push_request(OP_PREV_CLEAR, POS_W'(63),      '0, '0);        // full word down to 0: miss
    push_request(OP_PREV_SET,   POS_W'(4094),    '0, '0);        // skips the top bit
    push_request(OP_WRITE,      '0, WIDX_W'(63), ALL_ONES);
    push_request(OP_NEXT_CLEAR, POS_W'(4032),    '0, '0);        // no clear bit up to the end
    push_request(OP_PREV_CLEAR, POS_W'(4095),    '0, '0);        // just below the top word
    push_request(OP_NEXT_SET,   POS_W'(64),      '0, '0);        // walk from word 1 upward
    push_request(OP_SPARE_FIRST, '1, '1, ALL_ONES);              // unused codes leave map alone
    push_request(OP_W'(OP_SPARE_FIRST + 1), '1, '1, ALL_ONES);
    push_request(OP_SPARE_LAST, '1, '1, ALL_ONES);
    push_request(OP_PREV_CLEAR, POS_W'(4095),    '0, '0);
    push_request(OP_WRITE,      '0,              '0, '0);
    push_request(OP_WRITE,      '0, WIDX_W'(63), '0);

    // Size settings: saturating, zero, one bit, full, and odd sizes around word edges.
    size_plan = '{8191, 0, 1, 4096, 100, 64, 65, 63, 0, 0, 0};
    size_plan[8]  = $urandom_range(2, 4095);
    size_plan[9]  = $urandom_range(4097, 8191);
    size_plan[10] = $urandom_range(1, 200);

    foreach (size_plan[i]) begin
      wait_idle(4);
      set_map_size(size_plan[i]);
      run_random((size_plan[i] == 0) ? 40 : 160);
    end

    wait_idle(SETTLE_CYCLES);
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
